// ===== sv/ral_pkg.sv =====
// Shared types, constants and register codes for the RADIUS attribute locator.
package ral_pkg;

	// Largest region walked; bytes at or past this position end the search
	localparam int MAX_REGION_BYTES = 1024;
	localparam int POS_W = $clog2(MAX_REGION_BYTES + 1);
	localparam int OFS_W = 10;

	// Vendor-Specific attribute type and the shortest legal attribute length
	localparam logic [7:0] VSA_TYPE = 8'd26;
	localparam logic [7:0] MIN_ATTR_LEN = 8'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_NUMBER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VENDOR_SUBTYPE = 2'd3;

	// Configuration reset values
	localparam logic [7:0] RST_TARGET_TYPE = 8'd79;
	localparam logic RST_VENDOR_MODE = 1'b0;
	localparam logic [31:0] RST_VENDOR_NUMBER = 32'd311;
	localparam logic [7:0] RST_VENDOR_SUBTYPE = 8'd17;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic [OFS_W-1:0] value_offset;
		logic [7:0] value_length;
	} out_item_t;

	typedef struct packed {
		logic [7:0] target_type;
		logic vendor_mode;
		logic [31:0] vendor_number;
		logic [7:0] vendor_subtype;
	} cfg_t;

endpackage

// ===== sv/ral_cfg_regs.sv =====
// Configuration register file of the RADIUS attribute locator.
module ral_cfg_regs
	import ral_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [31:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_type <= RST_TARGET_TYPE;
			cfg_q.vendor_mode <= RST_VENDOR_MODE;
			cfg_q.vendor_number <= RST_VENDOR_NUMBER;
			cfg_q.vendor_subtype <= RST_VENDOR_SUBTYPE;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TARGET_TYPE: cfg_q.target_type <= wr_data[7:0];
				CFG_VENDOR_MODE: cfg_q.vendor_mode <= wr_data[0];
				CFG_VENDOR_NUMBER: cfg_q.vendor_number <= wr_data;
				CFG_VENDOR_SUBTYPE: cfg_q.vendor_subtype <= wr_data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/ral_parser.sv =====
// Per-byte attribute walker: search state and the combinational next-state update of it.
module ral_parser
	import ral_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  in_item_t item,
	input  cfg_t cfg,
	output logic res_valid,
	output out_item_t res
);

	typedef enum logic [1:0] {O_TYPE, O_LEN, O_BODY} outer_phase_t;
	typedef enum logic [1:0] {I_OFF, I_TYPE, I_LEN, I_BODY} inner_phase_t;

	// Control state
	logic [POS_W-1:0] pos_q, pos_n;
	outer_phase_t ophase_q, ophase_n;
	inner_phase_t iphase_q, iphase_n;
	logic [2:0] vbs_q, vbs_n;
	logic cv_q, cv_n;
	logic over_q, over_n;

	// Payload state
	logic [7:0] otype_q, otype_n;
	logic [OFS_W-1:0] ostart_q, ostart_n;
	logic [7:0] oleft_q, oleft_n;
	logic [7:0] olen_q, olen_n;
	logic [23:0] shift_q, shift_n;
	logic [7:0] itype_q, itype_n;
	logic [7:0] ileft_q, ileft_n;
	logic [OFS_W-1:0] istart_q, istart_n;
	logic [OFS_W-1:0] cofs_q, cofs_n;
	logic [7:0] clen_q, clen_n;

	logic [7:0] b;
	logic [7:0] remain;
	logic attr_end;
	logic short_end;
	logic hit;
	logic in_vsa;

	assign b = item.data_byte;
	assign in_vsa = cfg.vendor_mode && (otype_q == VSA_TYPE);

	// Next-state for one byte
	always_comb begin
		pos_n = pos_q;
		ophase_n = ophase_q;
		iphase_n = iphase_q;
		vbs_n = vbs_q;
		cv_n = cv_q;
		over_n = over_q;
		otype_n = otype_q;
		ostart_n = ostart_q;
		oleft_n = oleft_q;
		olen_n = olen_q;
		shift_n = shift_q;
		itype_n = itype_q;
		ileft_n = ileft_q;
		istart_n = istart_q;
		cofs_n = cofs_q;
		clen_n = clen_q;
		remain = oleft_q;
		attr_end = 1'b0;
		short_end = 1'b0;
		hit = 1'b0;

		// Give up on regions longer than the limit
		if (!over_n && pos_q >= POS_W'(MAX_REGION_BYTES)) begin
			over_n = 1'b1;
			cv_n = 1'b0;
		end

		// Walk the top-level attribute
		if (!over_n) begin
			unique case (ophase_q)
				O_TYPE: begin
					otype_n = b;
					ostart_n = OFS_W'(pos_q);
					ophase_n = O_LEN;
				end
				O_LEN: begin
					shift_n = '0;
					vbs_n = '0;
					iphase_n = I_OFF;
					cv_n = 1'b0;
					if (b < MIN_ATTR_LEN) begin
						over_n = 1'b1;
					end else begin
						oleft_n = b - MIN_ATTR_LEN;
						olen_n = b - MIN_ATTR_LEN;
						if (b == MIN_ATTR_LEN) begin
							attr_end = 1'b1;
							short_end = item.last_byte;
						end else begin
							ophase_n = O_BODY;
						end
					end
				end
				default: begin
					if (oleft_q != 8'd0) begin
						oleft_n = oleft_q - 8'd1;
					end
					// Vendor attribute body: vendor id, then sub-attributes
					if (in_vsa) begin
						if (vbs_q < 3'd4) begin
							shift_n = {shift_q[15:0], b};
							vbs_n = vbs_q + 3'd1;
							if (vbs_q == 3'd3) begin
								iphase_n = ({shift_q, b} == cfg.vendor_number) ? I_TYPE : I_OFF;
							end
						end else begin
							unique case (iphase_q)
								I_TYPE: begin
									if (remain <= 8'd2) begin
										iphase_n = I_OFF;
									end else begin
										itype_n = b;
										istart_n = OFS_W'(pos_q);
										iphase_n = I_LEN;
									end
								end
								I_LEN: begin
									if (b < MIN_ATTR_LEN || (b - 8'd1) > remain) begin
										iphase_n = I_OFF;
									end else if (itype_q == cfg.vendor_subtype) begin
										cv_n = 1'b1;
										cofs_n = istart_q + OFS_W'(2);
										clen_n = b - MIN_ATTR_LEN;
										iphase_n = I_OFF;
									end else begin
										ileft_n = b - MIN_ATTR_LEN;
										iphase_n = (b == MIN_ATTR_LEN) ? I_TYPE : I_BODY;
									end
								end
								I_BODY: begin
									if (ileft_q != 8'd0) begin
										ileft_n = ileft_q - 8'd1;
									end
									if (ileft_n == 8'd0) begin
										iphase_n = I_TYPE;
									end
								end
								I_OFF: begin
								end
							endcase
						end
					end
					if (oleft_n == 8'd0) begin
						attr_end = 1'b1;
					end
				end
			endcase
		end

		// Close the attribute and decide on a match
		if (attr_end) begin
			ophase_n = O_TYPE;
			oleft_n = 8'd0;
			if (cfg.vendor_mode) begin
				if (otype_q == VSA_TYPE && cv_n) begin
					over_n = 1'b1;
					hit = 1'b1;
				end else begin
					cv_n = 1'b0;
					iphase_n = I_OFF;
				end
			end else if (otype_q == cfg.target_type && !short_end) begin
				cv_n = 1'b1;
				cofs_n = ostart_q + OFS_W'(2);
				clen_n = olen_n;
				over_n = 1'b1;
				hit = 1'b1;
			end
		end

		// Report a match, or not-found at the end of an unreported region
		res_valid = hit || (item.last_byte && !(over_n && cv_n));
		res.found = hit;
		res.value_offset = hit ? cofs_n : '0;
		res.value_length = hit ? clen_n : 8'd0;

		// Advance the saturating byte position
		if (pos_q < POS_W'(MAX_REGION_BYTES)) begin
			pos_n = pos_q + POS_W'(1);
		end

		// Drop the search control state after the last byte
		if (item.last_byte) begin
			pos_n = '0;
			ophase_n = O_TYPE;
			iphase_n = I_OFF;
			vbs_n = '0;
			cv_n = 1'b0;
			over_n = 1'b0;
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ophase_q <= O_TYPE;
			iphase_q <= I_OFF;
			vbs_q <= '0;
			cv_q <= 1'b0;
			over_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_n;
			ophase_q <= ophase_n;
			iphase_q <= iphase_n;
			vbs_q <= vbs_n;
			cv_q <= cv_n;
			over_q <= over_n;
		end
	end

	// Hold payload state; each field is written before it is read
	always_ff @(posedge clk) begin
		if (step) begin
			otype_q <= otype_n;
			ostart_q <= ostart_n;
			oleft_q <= oleft_n;
			olen_q <= olen_n;
			shift_q <= shift_n;
			itype_q <= itype_n;
			ileft_q <= ileft_n;
			istart_q <= istart_n;
			cofs_q <= cofs_n;
			clen_q <= clen_n;
		end
	end

endmodule

// ===== sv/ral_out_buf.sv =====
// Result register with a skid entry so the parser keeps running under backpressure until the skid fills.
module ral_out_buf
	import ral_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  out_item_t push_item,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_item
);

	logic out_valid_q;
	logic skid_valid_q;
	out_item_t out_item_q;
	out_item_t skid_item_q;

	// Control: main slot and skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (push) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= push;
		end
	end

	// Payload: park in skid while stalled, else load the main slot
	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (push) begin
				skid_item_q <= push_item;
			end
		end else if (skid_valid_q) begin
			out_item_q <= skid_item_q;
		end else if (push) begin
			out_item_q <= push_item;
		end
	end

	assign full = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

// ===== sv/radius_attribute_locator_unit.sv =====
// Top level of the RADIUS attribute locator: input register, parser, result buffer.
// Feed the attribute region of one RADIUS packet (header excluded) one byte per
// transfer, marking the final byte with last_byte. The unit takes one byte every
// cycle unless the result buffer is full; a byte that causes a result passes the
// input register, then the parse step into the result register. Each region gives
// exactly one result: a match with its value offset and length, reported at the
// byte that completes the matching top-level attribute, or a not-found result with
// zero offset and length at the last byte. A two-entry result buffer absorbs one
// stalled result; input is held off only while both entries are full. The
// configuration port is always ready; write it only between regions.
module radius_attribute_locator_unit
	import ral_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output out_item_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg;
	logic valid_s1;
	in_item_t item_s1;
	logic step;
	logic full;
	logic res_valid;
	out_item_t res;

	assign cfg_ready = 1'b1;

	ral_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	// Input register: advance whenever the result buffer has room
	assign step = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	ral_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.cfg(cfg),
		.res_valid(res_valid),
		.res(res)
	);

	ral_out_buf u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(step && res_valid),
		.push_item(res),
		.full(full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

endmodule

// ===== tb/sv/ral_location_checker.sv =====
// Result checker for the RADIUS attribute locator: predicts each region's outcome and compares.
module ral_location_checker
	import ral_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_item_t in_item,
	input  logic out_valid,
	input  logic out_ready,
	input  out_item_t out_item,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int mismatches,
	output int awaiting,
	output int matches_seen,
	output int misses_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {WALK_TYPE, WALK_LEN, WALK_BODY} walk_phase_t;
	typedef enum logic [1:0] {SUB_OFF, SUB_TYPE, SUB_LEN, SUB_BODY} sub_phase_t;

	// Shadow copy of the registers and of the attribute walk
	cfg_t regs;
	logic [POS_W-1:0] byte_pos;
	walk_phase_t walk_phase;
	logic [7:0] attr_type;
	logic [7:0] attr_left;
	logic [POS_W-1:0] attr_start;
	logic [31:0] vid_shift;
	logic [2:0] vid_count;
	sub_phase_t sub_phase;
	logic [7:0] sub_type;
	logic [7:0] sub_left;
	logic [POS_W-1:0] sub_start;
	logic cand_valid;
	logic [OFS_W-1:0] cand_offset;
	logic [7:0] cand_length;
	logic search_done;

	// Locations predicted but not yet seen on the result channel
	out_item_t awaited_locations[$];

	function automatic void clear_walk();
		byte_pos = '0;
		walk_phase = WALK_TYPE;
		attr_type = '0;
		attr_left = '0;
		attr_start = '0;
		vid_shift = '0;
		vid_count = '0;
		sub_phase = SUB_OFF;
		sub_type = '0;
		sub_left = '0;
		sub_start = '0;
		cand_valid = 1'b0;
		cand_offset = '0;
		cand_length = '0;
		search_done = 1'b0;
	endfunction

	function automatic void abandon();
		search_done = 1'b1;
		cand_valid = 1'b0;
	endfunction

	// One byte inside a Vendor-Specific attribute; remain counts this byte
	function automatic void vendor_step(input logic [7:0] b, input int remain,
			input logic [POS_W-1:0] pos);
		if (vid_count < 3'd4) begin
			vid_shift = {vid_shift[23:0], b};
			vid_count++;
			if (vid_count == 3'd4)
				sub_phase = (vid_shift == regs.vendor_number) ? SUB_TYPE : SUB_OFF;
			return;
		end
		case (sub_phase)
			SUB_TYPE: begin
				if (remain <= 2) begin
					sub_phase = SUB_OFF;
				end else begin
					sub_type = b;
					sub_start = pos;
					sub_phase = SUB_LEN;
				end
			end
			SUB_LEN: begin
				if (b < MIN_ATTR_LEN || int'(b) - 1 > remain) begin
					sub_phase = SUB_OFF;
				end else if (sub_type == regs.vendor_subtype) begin
					cand_valid = 1'b1;
					cand_offset = OFS_W'(sub_start + 2);
					cand_length = b - MIN_ATTR_LEN;
					sub_phase = SUB_OFF;
				end else begin
					sub_left = b - MIN_ATTR_LEN;
					sub_phase = (sub_left == 0) ? SUB_TYPE : SUB_BODY;
				end
			end
			SUB_BODY: begin
				if (sub_left > 0)
					sub_left--;
				if (sub_left == 0)
					sub_phase = SUB_TYPE;
			end
			default: ;
		endcase
	endfunction

	// Top-level attribute complete; returns 1 when it is the match
	function automatic logic close_attribute(input logic short_at_end);
		walk_phase = WALK_TYPE;
		if (regs.vendor_mode) begin
			if (attr_type == VSA_TYPE && cand_valid) begin
				search_done = 1'b1;
				return 1'b1;
			end
			cand_valid = 1'b0;
			sub_phase = SUB_OFF;
			return 1'b0;
		end
		if (attr_type == regs.target_type && !short_at_end) begin
			cand_valid = 1'b1;
			cand_offset = OFS_W'(attr_start + 2);
			cand_length = attr_left;
			search_done = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the walk by one byte; returns 1 when the byte yields a result
	function automatic logic predict_location(input in_item_t item, output out_item_t res);
		logic [POS_W-1:0] pos;
		int remain;
		int span;
		logic hit;
		logic reported;
		pos = byte_pos;
		hit = 1'b0;
		res = '0;
		if (!search_done && pos >= MAX_REGION_BYTES)
			abandon();
		if (!search_done) begin
			case (walk_phase)
				WALK_TYPE: begin
					attr_type = item.data_byte;
					attr_start = pos;
					walk_phase = WALK_LEN;
				end
				WALK_LEN: begin
					vid_shift = '0;
					vid_count = '0;
					sub_phase = SUB_OFF;
					cand_valid = 1'b0;
					if (item.data_byte < MIN_ATTR_LEN) begin
						abandon();
					end else begin
						attr_left = item.data_byte - MIN_ATTR_LEN;
						if (attr_left == 0)
							hit = close_attribute(item.last_byte);
						else
							walk_phase = WALK_BODY;
					end
				end
				default: begin
					remain = attr_left;
					if (attr_left > 0)
						attr_left--;
					if (regs.vendor_mode && attr_type == VSA_TYPE)
						vendor_step(item.data_byte, remain, pos);
					if (attr_left == 0) begin
						// value length for a top-level report
						span = int'(pos) + 1 - (int'(attr_start) + 2);
						attr_left = span[7:0];
						hit = close_attribute(1'b0);
						attr_left = '0;
					end
				end
			endcase
		end
		if (byte_pos < MAX_REGION_BYTES)
			byte_pos++;
		if (hit) begin
			res.found = 1'b1;
			res.value_offset = cand_offset;
			res.value_length = cand_length;
			if (item.last_byte)
				clear_walk();
			return 1'b1;
		end
		if (item.last_byte) begin
			// a found result is never followed by a not-found one
			reported = search_done && cand_valid;
			clear_walk();
			return !reported;
		end
		return 1'b0;
	endfunction

	// Compare results, then track register writes and byte transfers
	always @(posedge clk or negedge arst_n) begin : track
		out_item_t want;
		out_item_t fresh;
		if (!arst_n) begin
			regs.target_type = RST_TARGET_TYPE;
			regs.vendor_mode = RST_VENDOR_MODE;
			regs.vendor_number = RST_VENDOR_NUMBER;
			regs.vendor_subtype = RST_VENDOR_SUBTYPE;
			clear_walk();
			awaited_locations.delete();
			mismatches = 0;
			matches_seen = 0;
			misses_seen = 0;
			awaiting = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_locations.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got %0b/%0d/%0d (found/ofs/len)",
						$time, out_item.found, out_item.value_offset,
						out_item.value_length);
				end else begin
					want = awaited_locations.pop_front();
					if (out_item.found !== want.found
							|| out_item.value_offset !== want.value_offset
							|| out_item.value_length !== want.value_length) begin
						mismatches++;
						$display("%0t: expected found/ofs/len %0b/%0d/%0d, got %0b/%0d/%0d",
							$time, want.found, want.value_offset, want.value_length,
							out_item.found, out_item.value_offset, out_item.value_length);
					end else if (want.found) begin
						matches_seen++;
					end else begin
						misses_seen++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (predict_location(in_item, fresh))
					awaited_locations.push_back(fresh);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TARGET_TYPE: regs.target_type = cfg_data[7:0];
					CFG_VENDOR_MODE: regs.vendor_mode = cfg_data[0];
					CFG_VENDOR_NUMBER: regs.vendor_number = cfg_data;
					CFG_VENDOR_SUBTYPE: regs.vendor_subtype = cfg_data[7:0];
					default: ;
				endcase
			end
			awaiting = awaited_locations.size();
		end
	end

endmodule

// ===== tb/sv/tb_radius_attribute_locator_unit.sv =====
// Testbench top for the RADIUS attribute locator unit: reset, region stimulus and verdict.
module tb_radius_attribute_locator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ral_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RANDOM_ITEMS = 600;
	localparam int REGIONS_PER_SETTING = 2;
	localparam int DRAIN_CYCLES = 6;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_TARGET_TYPE;
	logic [31:0] cfg_data = '0;

	int mismatches;
	int awaiting;
	int matches_seen;
	int misses_seen;

	int send_gap_pct = 21;
	int take_gap_pct = 66;
	int bytes_sent = 0;
	int regions_sent = 0;
	int settings_loaded = 0;
	int quiet_cycles = 0;

	// Region under construction, one attribute byte per entry
	logic [7:0] region_bytes[$];

	always #(CLK_PERIOD / 2) clk = ~clk;

	radius_attribute_locator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ral_location_checker locator_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.awaiting(awaiting),
		.matches_seen(matches_seen),
		.misses_seen(misses_seen)
	);

	// Stall the result side at random
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= take_gap_pct);

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, awaiting);
			$display("status: fail");
			$finish;
		end
	end

	function automatic void put_tlv(input logic [7:0] kind, input int len_field,
			input int body_len);
		region_bytes.push_back(kind);
		region_bytes.push_back(8'(len_field));
		repeat (body_len)
			region_bytes.push_back(8'($urandom));
	endfunction

	// Top-level walk: mostly well-formed, some short, overrun, trailing or noise
	function automatic void make_plain_region(input cfg_t c);
		int n;
		int len;
		region_bytes.delete();
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 255) : $urandom_range(2, 24);
			put_tlv(($urandom_range(0, 3) == 0) ? c.target_type : 8'($urandom), len, len - 2);
		end
		case ($urandom_range(0, 11))
			0: begin
				put_tlv(8'($urandom), $urandom_range(0, 1), $urandom_range(0, 3));
				put_tlv(c.target_type, 4, 2);
			end
			1: begin
				len = $urandom_range(3, 30);
				put_tlv(c.target_type, len, $urandom_range(0, len - 3));
			end
			2: repeat ($urandom_range(1, 2)) region_bytes.push_back(8'($urandom));
			3: put_tlv(c.target_type, 2, 0);
			4: begin
				region_bytes.delete();
				repeat ($urandom_range(1, 40)) region_bytes.push_back(8'($urandom));
			end
			default: ;
		endcase
	endfunction

	// Vendor walk: Vendor-Specific attributes with sub-attributes, some of them broken
	function automatic void make_vendor_region(input cfg_t c);
		int n;
		int m;
		int hdr;
		int len;
		int cut;
		int flaw;
		logic [31:0] id;
		logic [7:0] kind;
		region_bytes.delete();
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(2, 12);
				put_tlv(8'($urandom), len, len - 2);
				continue;
			end
			hdr = region_bytes.size();
			region_bytes.push_back(VSA_TYPE);
			region_bytes.push_back(8'd0);
			case ($urandom_range(0, 7))
				0: id = $urandom();
				1: id = c.vendor_number ^ (32'd1 << $urandom_range(0, 31));
				default: id = c.vendor_number;
			endcase
			cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
			for (int k = 0; k < cut; k++)
				region_bytes.push_back(id[31 - 8 * k -: 8]);
			if (cut == 4) begin
				m = $urandom_range(0, 4);
				for (int j = 0; j < m; j++) begin
					kind = ($urandom_range(0, 2) == 0) ? 8'($urandom) : c.vendor_subtype;
					len = $urandom_range(2, 10);
					flaw = $urandom_range(0, 11);
					if (flaw == 0) begin
						put_tlv(kind, $urandom_range(0, 1), $urandom_range(0, 3));
					end else if (flaw == 1) begin
						// declared length runs past the vendor attribute
						put_tlv(kind, len + $urandom_range(1, 8), len - 2);
						break;
					end else if (flaw == 2) begin
						repeat ($urandom_range(1, 2)) region_bytes.push_back(8'($urandom));
						break;
					end else begin
						put_tlv(kind, len, len - 2);
					end
				end
			end
			region_bytes[hdr + 1] = 8'(region_bytes.size() - hdr);
		end
		case ($urandom_range(0, 9))
			0: put_tlv(8'($urandom), $urandom_range(0, 1), $urandom_range(0, 3));
			1: begin
				len = $urandom_range(8, 30);
				put_tlv(VSA_TYPE, len, $urandom_range(0, len - 3));
			end
			2: repeat ($urandom_range(1, 2)) region_bytes.push_back(8'($urandom));
			default: ;
		endcase
	endfunction

	// Region near the size limit: target ends on the last allowed byte, or straddles it
	function automatic void make_long_region(input cfg_t c, input logic with_match);
		logic [7:0] filler;
		int room;
		region_bytes.delete();
		filler = c.target_type + 8'd1;
		while (region_bytes.size() < MAX_REGION_BYTES - 300)
			put_tlv(filler, 255, 253);
		if (with_match) begin
			room = MAX_REGION_BYTES - region_bytes.size();
			if (room > 255) begin
				put_tlv(filler, room - 100, room - 102);
				room = 100;
			end
			put_tlv(c.target_type, room, room - 2);
		end else begin
			while (region_bytes.size() < MAX_REGION_BYTES - 30)
				put_tlv(filler, 12, 10);
			put_tlv(c.target_type, 60, 58);
		end
		repeat (12)
			region_bytes.push_back(8'($urandom));
	endfunction

	function automatic cfg_t pick_settings(input int pass_no);
		cfg_t s;
		s.target_type = 8'($urandom);
		s.vendor_mode = 1'b0;
		s.vendor_number = $urandom();
		s.vendor_subtype = 8'($urandom);
		case (pass_no % 6)
			0: s.target_type = 8'h00;
			1: s.target_type = 8'hFF;
			2: if ($urandom_range(0, 2) == 0) s.target_type = VSA_TYPE;
			3: begin
				s.vendor_mode = 1'b1;
				s.vendor_number = '0;
				s.vendor_subtype = 8'h00;
			end
			4: begin
				s.vendor_mode = 1'b1;
				s.vendor_number = '1;
				s.vendor_subtype = 8'hFF;
			end
			default: s.vendor_mode = 1'b1;
		endcase
		return s;
	endfunction

	// Present one byte; hold it until the transfer
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{data_byte: b, last_byte: last};
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_region();
		for (int i = 0; i < region_bytes.size(); i++)
			send_byte(region_bytes[i], i == region_bytes.size() - 1);
		regions_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(CFG_TARGET_TYPE, {24'd0, c.target_type});
		write_reg(CFG_VENDOR_MODE, {31'd0, c.vendor_mode});
		write_reg(CFG_VENDOR_NUMBER, c.vendor_number);
		write_reg(CFG_VENDOR_SUBTYPE, {24'd0, c.vendor_subtype});
		cfg_valid <= 1'b0;
		settings_loaded++;
	endtask

	// Drop valid, wait out every predicted result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (awaiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		cfg_t s;
		int pass_no;
		int base;
		int progress;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed top-level cases under the reset settings
		s.target_type = RST_TARGET_TYPE;
		s.vendor_mode = RST_VENDOR_MODE;
		s.vendor_number = RST_VENDOR_NUMBER;
		s.vendor_subtype = RST_VENDOR_SUBTYPE;
		load_settings(s);
		region_bytes = '{8'd79, 8'd2};
		send_region();
		region_bytes = '{8'd79, 8'd3, 8'hFF};
		send_region();
		region_bytes = '{8'd5, 8'd1, 8'h00};
		send_region();
		region_bytes = '{8'h00, 8'd4, 8'hAA};
		send_region();
		region_bytes = '{8'hFF};
		send_region();
		settle();

		// Directed vendor cases at the register extremes
		s.target_type = 8'hFF;
		s.vendor_mode = 1'b1;
		s.vendor_number = '1;
		s.vendor_subtype = 8'hFF;
		load_settings(s);
		region_bytes = '{VSA_TYPE, 8'd9, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd3, 8'h5A};
		send_region();
		region_bytes = '{VSA_TYPE, 8'd5, 8'hFF, 8'hFF, 8'hFF};
		send_region();
		settle();

		// Random regions, idle pattern changing by thirds
		base = bytes_sent;
		pass_no = 0;
		while (bytes_sent - base < RANDOM_ITEMS) begin
			progress = bytes_sent - base;
			if (progress < RANDOM_ITEMS / 3) begin
				send_gap_pct = 21;
				take_gap_pct = 66;
			end else if (progress < 2 * RANDOM_ITEMS / 3) begin
				send_gap_pct = 66;
				take_gap_pct = 21;
			end else begin
				send_gap_pct = 0;
				take_gap_pct = 0;
			end
			s = pick_settings(pass_no);
			load_settings(s);
			repeat (REGIONS_PER_SETTING) begin
				if (s.vendor_mode)
					make_vendor_region(s);
				else
					make_plain_region(s);
				send_region();
			end
			settle();
			pass_no++;
		end

		// Region that runs past the size limit
		s = pick_settings(2);
		s.vendor_mode = 1'b0;
		load_settings(s);
		make_long_region(s, 1'b0);
		send_region();
		settle();

		$display("walked %0d regions (%0d bytes) under %0d register settings",
			regions_sent, bytes_sent, settings_loaded);
		$display("checked %0d matches and %0d not-found results, %0d mismatches",
			matches_seen, misses_seen, mismatches);
		if (mismatches == 0 && awaiting == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
